### hw/rtl/ar_txn_pkg.sv
// package for the ack/retry transaction engine: frame sizes, register indexes,
// phase codes and reset values shared by the rtl and its checker
// no dependencies
`default_nettype none

package ar_txn_pkg;

  // frame geometry
  localparam int unsigned HeaderBytes  = 7;
  localparam int unsigned PayloadBytes = 48;
  localparam int unsigned FrameMax     = HeaderBytes + PayloadBytes;

  // field widths
  localparam int unsigned RadioIdW  = 32;
  localparam int unsigned CmdIdW    = 8;
  localparam int unsigned DataLenW  = 6;
  localparam int unsigned RxLenW    = 8;
  localparam int unsigned ContextW  = 8;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned RetriesW  = 4;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 16;

  // item function codes
  localparam logic FuncSend = 1'b0;
  localparam logic FuncTick = 1'b1;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgRetryTimeout = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgMaxRetries   = 1'b1;

  // configuration reset values
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd120;
  localparam logic [RetriesW-1:0] RetriesReset = 4'd3;

  // phase codes as seen on the result
  localparam logic [PhaseW-1:0] PhIdleCode     = 3'd0;
  localparam logic [PhaseW-1:0] PhTransmitCode = 3'd1;
  localparam logic [PhaseW-1:0] PhWaitCode     = 3'd2;
  localparam logic [PhaseW-1:0] PhErrorCode    = 3'd3;
  localparam logic [PhaseW-1:0] PhDoneCode     = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/ack_retry_transaction_fsm_top.sv
// ack/retry transaction engine: input register, next-state logic, result register
// depends on ar_txn_pkg
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries send requests (func 0) and
//   service ticks (func 1). A send starts a transaction only when the engine is
//   idle, in error or done; a tick checks a received frame and steps the phase.
//   Output channel (out_valid_o / out_stall_i) gives one result item per input
//   item, in order: phase, transmit strobe, latched header and response length.
//   An accepted item passes from the input register to the result register,
//   which drives the outputs. Throughput: one item every cycle while
//   out_stall_i is low, the phase and its counters updating once per item.
//   Stall: while the result waits under out_stall_i, one more item is held in
//   the input register; after that in_stall_o rises until the result is taken.
//   Reset: phase idle, context and counters zero, header zero, timeout 120
//   ticks, 3 retries; both channels empty.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at the
//   next edge; the user must make them only while no item is in flight (unenforced).
`default_nettype none

module ack_retry_transaction_fsm_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // configuration
  input  wire                                   cfg_we_i,
  input  wire  [ar_txn_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  wire  [ar_txn_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // input channel
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire                                   func_i,
  input  wire  [ar_txn_pkg::RadioIdW-1:0]       radio_id_i,
  input  wire  [ar_txn_pkg::CmdIdW-1:0]         cmd_id_i,
  input  wire  [ar_txn_pkg::DataLenW-1:0]       data_len_i,
  input  wire                                   rx_valid_i,
  input  wire  [ar_txn_pkg::RxLenW-1:0]         rx_len_i,
  input  wire  [ar_txn_pkg::ContextW-1:0]       rx_context_i,
  input  wire                                   radio_accepts_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic                                  send_accepted_o,
  output logic [ar_txn_pkg::PhaseW-1:0]         phase_o,
  output logic                                  tx_request_o,
  output logic [ar_txn_pkg::RadioIdW-1:0]       tx_radio_id_o,
  output logic [ar_txn_pkg::ContextW-1:0]       tx_context_o,
  output logic [ar_txn_pkg::CmdIdW-1:0]         tx_cmd_id_o,
  output logic [ar_txn_pkg::DataLenW-1:0]       tx_len_o,
  output logic [ar_txn_pkg::DataLenW-1:0]       resp_len_o
);
  import ar_txn_pkg::*;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE     = PhIdleCode,
    PH_TRANSMIT = PhTransmitCode,
    PH_WAIT     = PhWaitCode,
    PH_ERROR    = PhErrorCode,
    PH_DONE     = PhDoneCode
  } phase_e;

  localparam logic [DataLenW-1:0] PayloadMax = DataLenW'(PayloadBytes);
  localparam logic [DataLenW:0]   HeaderExt  = (DataLenW+1)'(HeaderBytes);
  localparam logic [DataLenW:0]   TxLenSat   = {1'b0, {DataLenW{1'b1}}};
  localparam logic [RxLenW-1:0]   RxLenMin   = RxLenW'(HeaderBytes);
  localparam logic [RxLenW-1:0]   RxLenMax   = RxLenW'(FrameMax);

  // configuration registers
  logic [TimeoutW-1:0] timeout_q;
  logic [RetriesW-1:0] max_retries_q;

  // input register
  logic                in_vld_q;
  logic                func_q;
  logic [RadioIdW-1:0] radio_id_q;
  logic [CmdIdW-1:0]   cmd_id_q;
  logic [DataLenW-1:0] data_len_q;
  logic                rx_valid_q;
  logic [RxLenW-1:0]   rx_len_q;
  logic [ContextW-1:0] rx_context_q;
  logic                radio_accepts_q;

  // engine state
  phase_e              phase_q, phase_d, phase_rx;
  logic [ContextW-1:0] ctx_q, ctx_d;
  logic [RetriesW-1:0] retries_q, retries_d;
  logic [TimeoutW-1:0] wait_q, wait_d;
  logic [DataLenW-1:0] flen_tx_q, flen_tx_d;
  logic [RxLenW-1:0]   flen_rx_q, flen_rx_d;
  logic [RadioIdW-1:0] hdr_radio_q, hdr_radio_d;
  logic [CmdIdW-1:0]   hdr_cmd_q, hdr_cmd_d;

  // result register
  logic                out_vld_q;
  logic                res_acc_q, res_acc_d;
  logic                res_txreq_q, res_txreq_d;
  logic [DataLenW-1:0] res_resp_q, res_resp_d;

  logic                adv;
  logic                busy;
  logic                rx_ok;
  logic [DataLenW-1:0] dlen_sat;
  logic [DataLenW:0]   total;
  logic [RxLenW-1:0]   resp_full;

  // handshake: the item in the input register moves on when the result slot frees
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TimeoutReset;
      max_retries_q <= RetriesReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRetryTimeout: timeout_q     <= cfg_wdata_i[TimeoutW-1:0];
        CfgMaxRetries:   max_retries_q <= cfg_wdata_i[RetriesW-1:0];
        default:         ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      func_q          <= func_i;
      radio_id_q      <= radio_id_i;
      cmd_id_q        <= cmd_id_i;
      data_len_q      <= data_len_i;
      rx_valid_q      <= rx_valid_i;
      rx_len_q        <= rx_len_i;
      rx_context_q    <= rx_context_i;
      radio_accepts_q <= radio_accepts_i;
    end
  end

  // frame length of a new request, payload clipped then total saturated
  assign busy     = (phase_q == PH_TRANSMIT) || (phase_q == PH_WAIT);
  assign dlen_sat = (data_len_q > PayloadMax) ? PayloadMax : data_len_q;
  always_comb begin
    total = {1'b0, dlen_sat} + HeaderExt;
    if (total > TxLenSat) begin
      total = TxLenSat;
    end
  end

  // received frame check: length must fit, context decides completion
  assign rx_ok = rx_valid_q && busy && (rx_len_q > RxLenMin) && (rx_len_q <= RxLenMax);
  always_comb begin
    phase_rx = phase_q;
    if (rx_ok && (rx_context_q == ctx_q)) begin
      phase_rx = PH_DONE;
    end
  end

  // next state for one item
  always_comb begin
    phase_d     = phase_q;
    ctx_d       = ctx_q;
    retries_d   = retries_q;
    wait_d      = wait_q;
    flen_tx_d   = flen_tx_q;
    flen_rx_d   = flen_rx_q;
    hdr_radio_d = hdr_radio_q;
    hdr_cmd_d   = hdr_cmd_q;
    res_acc_d   = 1'b0;
    res_txreq_d = 1'b0;
    if (func_q == FuncSend) begin
      if (!busy) begin
        ctx_d       = ctx_q + ContextW'(1);
        flen_tx_d   = total[DataLenW-1:0];
        retries_d   = max_retries_q;
        wait_d      = timeout_q;
        phase_d     = PH_TRANSMIT;
        hdr_radio_d = radio_id_q;
        hdr_cmd_d   = cmd_id_q;
        res_acc_d   = 1'b1;
      end
    end else begin
      if (rx_ok) begin
        flen_rx_d = rx_len_q;
      end
      phase_d = phase_rx;
      unique case (phase_rx)
        PH_TRANSMIT: begin
          if (radio_accepts_q) begin
            res_txreq_d = 1'b1;
            phase_d     = (wait_q != '0) ? PH_WAIT : PH_IDLE;
          end
        end
        PH_WAIT: begin
          if (wait_q != '0) begin
            wait_d = wait_q - TimeoutW'(1);
          end else if (retries_q != '0) begin
            retries_d = retries_q - RetriesW'(1);
            wait_d    = timeout_q;
            phase_d   = PH_TRANSMIT;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        default: ;
      endcase
    end
  end

  // response length once done
  assign resp_full  = flen_rx_d - RxLenMin;
  assign res_resp_d = ((phase_d == PH_DONE) && (flen_rx_d > RxLenMin)) ?
                      resp_full[DataLenW-1:0] : '0;

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ctx_q       <= '0;
      retries_q   <= '0;
      wait_q      <= '0;
      flen_tx_q   <= '0;
      flen_rx_q   <= '0;
      hdr_radio_q <= '0;
      hdr_cmd_q   <= '0;
      out_vld_q   <= 1'b0;
      res_acc_q   <= 1'b0;
      res_txreq_q <= 1'b0;
      res_resp_q  <= '0;
    end else begin
      if (adv) begin
        phase_q     <= phase_d;
        ctx_q       <= ctx_d;
        retries_q   <= retries_d;
        wait_q      <= wait_d;
        flen_tx_q   <= flen_tx_d;
        flen_rx_q   <= flen_rx_d;
        hdr_radio_q <= hdr_radio_d;
        hdr_cmd_q   <= hdr_cmd_d;
        res_acc_q   <= res_acc_d;
        res_txreq_q <= res_txreq_d;
        res_resp_q  <= res_resp_d;
        out_vld_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // outputs; header and phase registers double as the result fields
  assign out_valid_o     = out_vld_q;
  assign send_accepted_o = res_acc_q;
  assign phase_o         = phase_q;
  assign tx_request_o    = res_txreq_q;
  assign tx_radio_id_o   = hdr_radio_q;
  assign tx_context_o    = ctx_q;
  assign tx_cmd_id_o     = hdr_cmd_q;
  assign tx_len_o        = flen_tx_q;
  assign resp_len_o      = res_resp_q;

endmodule

`default_nettype wire

### hw/rtl/ar_txn_checker.sv
// port-level checker for the ack/retry transaction engine, bound to the top level
// depends on ar_txn_pkg and ack_retry_transaction_fsm_top
`default_nettype none

module ar_txn_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              out_valid_o,
  input wire                              out_stall_i,
  input wire                              send_accepted_o,
  input wire [ar_txn_pkg::PhaseW-1:0]     phase_o,
  input wire                              tx_request_o,
  input wire [ar_txn_pkg::ContextW-1:0]   tx_context_o,
  input wire [ar_txn_pkg::DataLenW-1:0]   resp_len_o
);
  import ar_txn_pkg::*;

  // a stalled item holds its place and its context
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_context_o))
    else $error("stalled item changed");

  // an accepted send always leaves the engine transmitting
  a_send_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_accepted_o |-> phase_o == PhTransmitCode)
    else $error("accepted send not in transmit phase");

  // a response length only shows when the transaction is done
  a_resp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (resp_len_o != '0) |-> phase_o == PhDoneCode)
    else $error("response length outside done phase");

  // a transmit leaves the engine waiting or idle and never comes from a send
  a_tx_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_request_o |->
      !send_accepted_o && (phase_o == PhWaitCode || phase_o == PhIdleCode))
    else $error("transmit strobe with wrong phase");

endmodule

bind ack_retry_transaction_fsm_top ar_txn_checker u_ar_txn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .send_accepted_o (send_accepted_o),
  .phase_o         (phase_o),
  .tx_request_o    (tx_request_o),
  .tx_context_o    (tx_context_o),
  .resp_len_o      (resp_len_o)
);

`default_nettype wire
